// ----- rtl/hona_pkg.sv -----
`timescale 1ns / 1ps
package hona_pkg;
  localparam int MaxNeighborsDef = 64;
  localparam int CordicStepsDef  = 16;
  localparam int TableLen        = 24;
  localparam int PosW            = 20;
  localparam int OutW            = 16;
  localparam int CntOutW         = 7;
  localparam int StatW           = 2;
  localparam int DW              = 21;
  localparam int CW              = 34;  // CORDIC datapath width
  localparam int AW              = 32;  // binary angle width

  localparam logic [StatW-1:0] ST_OK    = 2'd0;
  localparam logic [StatW-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatW-1:0] ST_DROP  = 2'd2;

  localparam logic signed [CW-1:0] CordicGain = 34'sd163008218;

  // unit operating modes
  localparam logic MODE_VEC = 1'b0;
  localparam logic MODE_ROT = 1'b1;

  typedef struct packed {
    logic             start;
    logic             mode;
    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] y0;
    logic [AW-1:0]    z0;
  } cordic_req_t;

  typedef struct packed {
    logic             done;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [AW-1:0]    z;
  } cordic_rsp_t;

  function automatic logic [AW-1:0] atan_turn(input logic [4:0] i);
    logic [AW-1:0] r;
    begin
      case (i)
        5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
        5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
        5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
        5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
        5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
        5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
        5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
        5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
        5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
        5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
        5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
        5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
        default: r = '0;
      endcase
      return r;
    end
  endfunction
endpackage

// ----- rtl/hona_cordic.sv -----
`timescale 1ns / 1ps
module hona_cordic #(
  parameter int CORDIC_STEPS = hona_pkg::CordicStepsDef
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hona_pkg::cordic_req_t req,
  output hona_pkg::cordic_rsp_t rsp
);
  import hona_pkg::*;

  localparam int NSteps = (CORDIC_STEPS < TableLen) ? CORDIC_STEPS : TableLen;

  logic                 busy_r, busy_nxt;
  logic                 mode_r, mode_nxt;
  logic [4:0]           i_r, i_nxt;
  logic signed [CW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [AW-1:0]        z_r, z_nxt;
  logic                 done_r, done_nxt;
  logic signed [CW-1:0] xs, ys;
  logic                 dir_pos;

  // one micro-rotation per cycle; arithmetic shift equals floor
  always_comb begin
    xs = x_r >>> i_r;
    ys = y_r >>> i_r;
    dir_pos = (mode_r == MODE_VEC) ? !y_r[CW-1] : !z_r[AW-1];
    busy_nxt = busy_r;
    mode_nxt = mode_r;
    i_nxt    = i_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    done_nxt = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
      mode_nxt = req.mode;
      i_nxt    = '0;
      x_nxt    = req.x0;
      y_nxt    = req.y0;
      z_nxt    = req.z0;
    end else if (busy_r) begin
      if ((mode_r == MODE_VEC) == dir_pos) begin
        // vectoring y>=0 or rotating z<0
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
      end else begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
      end
      if (dir_pos == (mode_r == MODE_VEC)) begin
        if (mode_r == MODE_VEC) z_nxt = z_r + atan_turn(i_r);
        else                    z_nxt = z_r + atan_turn(i_r);
      end else begin
        z_nxt = z_r - atan_turn(i_r);
      end
      if (i_r == 5'(NSteps - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
      i_nxt = i_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    mode_r <= mode_nxt;
    i_r    <= i_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.x    = x_r;
  assign rsp.y    = y_r;
  assign rsp.z    = z_r;
endmodule

// ----- rtl/hona_divider.sv -----
`timescale 1ns / 1ps
module hona_divider #(
  parameter int NW = 32,
  parameter int DVW = 11
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [NW-1:0]  num,
  input  logic [DVW-1:0] den,
  output logic           done,
  output logic [NW-1:0]  quo
);
  localparam int CntW = $clog2(NW + 1);

  logic            busy_r, busy_nxt, done_r, done_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0]   q_r, q_nxt;
  logic [DVW:0]    rem_r, rem_nxt;
  logic [DVW-1:0]  den_r, den_nxt;
  logic [DVW:0]    trial;

  // restoring division, one quotient bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    trial    = {rem_r[DVW-1:0], q_r[NW-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt   = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CntW'(NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;
endmodule

// ----- rtl/hexatic_order_neighbor_accumulator.sv -----
`timescale 1ns / 1ps
// Channel | Direction | Signals
// in_     | input     | in_valid/in_ready, own_x/y, nbr_x/y, same_frame, is_self, last
// out_    | output    | out_valid/out_ready, phi_re, phi_im, neighbor_count, status
// cfg_    | input     | cfg_we, cfg_data (max_range)
// Accept to next accept: a rejected, dropped or coincident candidate passes S_SQX,
// S_SQY, S_CMP and S_FIN; one that runs both CORDIC passes also passes S_WVEC,
// S_VEC, S_WROT and S_ACC. A last item adds S_OUT, held until out_ready, and with
// a nonzero count two serial divisions (S_DIVC, S_DIVS), one quotient bit per cycle.
// Both CORDIC passes share one micro-rotation unit; the squares share one multiplier.
// Synchronous active-low reset clears sums, count, the drop flag and the sequencer.
// in_ready is low while an item is in progress or a result waits on out_ready.
module hexatic_order_neighbor_accumulator #(
  parameter int MAX_NEIGHBORS = hona_pkg::MaxNeighborsDef,
  parameter int CORDIC_STEPS  = hona_pkg::CordicStepsDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [19:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [hona_pkg::PosW-1:0] in_own_x,
  input  logic signed [hona_pkg::PosW-1:0] in_own_y,
  input  logic signed [hona_pkg::PosW-1:0] in_nbr_x,
  input  logic signed [hona_pkg::PosW-1:0] in_nbr_y,
  input  logic in_same_frame,
  input  logic in_is_self,
  input  logic in_last,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [hona_pkg::OutW-1:0] out_phi_re,
  output logic signed [hona_pkg::OutW-1:0] out_phi_im,
  output logic [hona_pkg::CntOutW-1:0] out_neighbor_count,
  output logic [hona_pkg::StatW-1:0] out_status
);
  import hona_pkg::*;

  localparam int CntW = $clog2(MAX_NEIGHBORS + 1);
  localparam int SumW = 16 + CntW;
  localparam int DvW  = (CntW > 1) ? CntW : 2;

  localparam logic [3:0] S_IDLE = 4'd0, S_SQX = 4'd1, S_SQY = 4'd2, S_CMP = 4'd3,
                         S_VEC = 4'd4, S_ROT = 4'd5, S_ACC = 4'd6, S_FIN = 4'd7,
                         S_DIVC = 4'd8, S_DIVS = 4'd9, S_OUT = 4'd10,
                         S_WVEC = 4'd11, S_WROT = 4'd12;

  logic [3:0] st_r, st_nxt;
  logic [19:0] range_r;
  logic signed [DW-1:0] dx_r, dy_r;
  logic ok_r, last_r;
  logic [41:0] acc_r, acc_nxt, prod;
  logic [20:0] mul_a;
  logic signed [SumW-1:0] sc_r, ss_r, sc_nxt, ss_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic drop_r, drop_nxt;
  logic [1:0] q_r;
  logic signed [OutW-1:0] re_r, im_r, re_nxt, im_nxt;
  logic [CntOutW-1:0] oc_r, oc_nxt;
  logic [StatW-1:0] os_r, os_nxt;

  cordic_req_t creq;
  cordic_rsp_t crsp;
  logic dstart, ddone;
  logic [SumW-1:0] dnum, dquo;

  hona_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .req(creq), .rsp(crsp));

  hona_divider #(.NW(SumW), .DVW(DvW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .num(dnum),
    .den(DvW'(cnt_r)), .done(ddone), .quo(dquo));

  // shared squaring multiplier
  assign mul_a = (st_r == S_SQX) ? (dx_r[DW-1] ? 21'(-dx_r) : 21'(dx_r))
               : (st_r == S_SQY) ? (dy_r[DW-1] ? 21'(-dy_r) : 21'(dy_r))
               : {1'b0, range_r};
  assign prod = 42'(mul_a) * 42'(mul_a);

  function automatic logic signed [OutW-1:0] to_q14(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    begin
      r = (v + CW'(8192)) >>> 14;
      if (r > CW'(16384)) r = CW'(16384);
      if (r < -CW'(16384)) r = -CW'(16384);
      return OutW'(r);
    end
  endfunction

  logic signed [CW-1:0] cx, sy;
  logic [SumW-1:0] mag;
  logic [AW-1:0] a6, ar;
  logic [1:0] qd;
  logic signed [CW-1:0] vx0, vy0;

  always_comb begin
    unique case (q_r)
      2'd0: begin cx = crsp.x;  sy = crsp.y;  end
      2'd1: begin cx = -crsp.y; sy = crsp.x;  end
      2'd2: begin cx = -crsp.x; sy = -crsp.y; end
      default: begin cx = crsp.y; sy = -crsp.x; end
    endcase
    a6 = crsp.z * 32'd6;
    qd = 2'((a6 + 32'h20000000) >> 30);
    ar = a6 - {qd, 30'd0};
    vx0 = CW'(dy_r) <<< 10;
    vy0 = CW'(dx_r) <<< 10;
    // cosine sum goes first (started from S_FIN), sine sum second
    mag = (st_r == S_FIN) ? (sc_r[SumW-1] ? SumW'(-sc_r) : SumW'(sc_r))
                          : (ss_r[SumW-1] ? SumW'(-ss_r) : SumW'(ss_r));
    dnum = mag + SumW'(cnt_r >> 1);
  end

  always_comb begin
    st_nxt = st_r; acc_nxt = acc_r; sc_nxt = sc_r; ss_nxt = ss_r;
    cnt_nxt = cnt_r; drop_nxt = drop_r;
    re_nxt = re_r; im_nxt = im_r; oc_nxt = oc_r; os_nxt = os_r;
    creq = '0; dstart = 1'b0;
    unique case (st_r)
      S_IDLE: if (in_valid) st_nxt = S_SQX;
      S_SQX: begin acc_nxt = prod; st_nxt = S_SQY; end
      S_SQY: begin acc_nxt = acc_r + prod; st_nxt = S_CMP; end
      S_CMP: begin
        if (ok_r && acc_r < prod) begin
          if (cnt_r >= CntW'(MAX_NEIGHBORS)) begin
            drop_nxt = 1'b1; st_nxt = S_FIN;
          end else if (dx_r == '0 && dy_r == '0) begin
            sc_nxt = sc_r + SumW'(16384); cnt_nxt = cnt_r + 1'b1; st_nxt = S_FIN;
          end else begin
            creq.start = 1'b1; creq.mode = MODE_VEC;
            creq.x0 = vx0[CW-1] ? -vx0 : vx0;
            creq.y0 = vx0[CW-1] ? -vy0 : vy0;
            creq.z0 = vx0[CW-1] ? 32'h80000000 : '0;
            st_nxt = S_WVEC;
          end
        end else st_nxt = S_FIN;
      end
      S_WVEC: if (crsp.done) st_nxt = S_VEC;
      S_VEC: begin
        creq.start = 1'b1; creq.mode = MODE_ROT;
        creq.x0 = CordicGain; creq.y0 = '0; creq.z0 = ar;
        st_nxt = S_WROT;
      end
      S_WROT: if (crsp.done) st_nxt = S_ACC;
      S_ACC: begin
        sc_nxt = sc_r + SumW'(to_q14(cx));
        ss_nxt = ss_r + SumW'(to_q14(sy));
        cnt_nxt = cnt_r + 1'b1;
        st_nxt = S_FIN;
      end
      S_FIN: begin
        if (!last_r) st_nxt = S_IDLE;
        else if (cnt_r == '0) begin
          re_nxt = '0; im_nxt = '0; oc_nxt = '0; os_nxt = ST_EMPTY; st_nxt = S_OUT;
        end else begin
          dstart = 1'b1; st_nxt = S_DIVC;
        end
      end
      S_DIVC: if (ddone) begin
        re_nxt = OutW'(sc_r[SumW-1] ? -dquo : dquo);
        dstart = 1'b1; st_nxt = S_DIVS;
      end
      S_DIVS: if (ddone) begin
        im_nxt = OutW'(ss_r[SumW-1] ? -dquo : dquo);
        oc_nxt = CntOutW'(cnt_r);
        os_nxt = drop_r ? ST_DROP : ST_OK;
        st_nxt = S_OUT;
      end
      S_OUT: if (out_ready) begin
        st_nxt = S_IDLE; sc_nxt = '0; ss_nxt = '0; cnt_nxt = '0; drop_nxt = 1'b0;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; range_r <= '0; sc_r <= '0; ss_r <= '0;
      cnt_r <= '0; drop_r <= 1'b0;
    end else begin
      st_r <= st_nxt; sc_r <= sc_nxt; ss_r <= ss_nxt;
      cnt_r <= cnt_nxt; drop_r <= drop_nxt;
      if (cfg_we) range_r <= cfg_data;
    end
    acc_r <= acc_nxt;
    re_r <= re_nxt; im_r <= im_nxt; oc_r <= oc_nxt; os_r <= os_nxt;
    if (st_r == S_IDLE && in_valid) begin
      dx_r <= DW'(in_nbr_x) - DW'(in_own_x);
      dy_r <= DW'(in_nbr_y) - DW'(in_own_y);
      ok_r <= in_same_frame && !in_is_self;
      last_r <= in_last;
    end
    if (st_r == S_VEC) q_r <= qd;
  end

  assign in_ready = (st_r == S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign out_phi_re = re_r;
  assign out_phi_im = im_r;
  assign out_neighbor_count = oc_r;
  assign out_status = os_r;
endmodule
